FILE: design/stms_pkg.sv
// ----------------------------------------------------------------------------
// stms_pkg: shared constants and types
// Sizes, register indexes, controller states and the command and status
// groups that pass between controller and datapath.
// ----------------------------------------------------------------------------
package stms_pkg;

  localparam int HIST_DEPTH    = 64;
  localparam int SLOT_W        = $clog2(HIST_DEPTH);
  localparam int CNT_W         = $clog2(HIST_DEPTH + 1);
  localparam int USED_W        = 7;
  localparam logic [31:0] START_HOLDOFF = 32'd5;

  // x = slot time - sample time needs 33 bits signed
  localparam int X_W           = 33;
  localparam int PROD_W        = 2 * X_W;
  localparam int SUM_W         = X_W + 1 + SLOT_W;
  localparam int ACC_W         = PROD_W + SLOT_W;
  localparam int WIDE_W        = ACC_W + CNT_W + 1;
  localparam int MUL_B_W       = SUM_W;
  localparam int MUL_CNT_W     = $clog2(MUL_B_W + 2);
  localparam int Q_W           = 33;
  localparam int DIV_CNT_W     = $clog2(Q_W + 2);
  localparam int RAM_W         = 64;
  localparam int CFG_ADDR_W    = 4;

  typedef enum logic [1:0] {
    REG_RPT_INTERVAL  = 2'd0,
    REG_DISCARD_HIGH  = 2'd1,
    REG_DISCARD_LOW   = 2'd2,
    REG_REPORT_MODE   = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    MSEL_N_SXY  = 2'd0,
    MSEL_SX_SY  = 2'd1,
    MSEL_N_SXX  = 2'd2,
    MSEL_SX_SX  = 2'd3
  } mul_sel_t;

  typedef struct packed {
    logic [15:0] rpt_interval;
    logic [6:0]  discard_high;
    logic [6:0]  discard_low;
    logic        report_mode;
  } cfg_t;

  typedef enum logic [18:0] {
    S_IDLE    = 19'd1 << 0,
    S_START   = 19'd1 << 1,
    S_STORE   = 19'd1 << 2,
    S_SCAN    = 19'd1 << 3,
    S_WINIT   = 19'd1 << 4,
    S_WRD     = 19'd1 << 5,
    S_WCHK    = 19'd1 << 6,
    S_WSQ     = 19'd1 << 7,
    S_WXY     = 19'd1 << 8,
    S_WACC    = 19'd1 << 9,
    S_WNEXT   = 19'd1 << 10,
    S_WEND    = 19'd1 << 11,
    S_MULGO   = 19'd1 << 12,
    S_MULWAIT = 19'd1 << 13,
    S_DIVM    = 19'd1 << 14,
    S_DIVMW   = 19'd1 << 15,
    S_DIVS    = 19'd1 << 16,
    S_DIVSW   = 19'd1 << 17,
    S_EMIT    = 19'd1 << 18
  } state_t;

  typedef struct packed {
    logic     accept;
    logic     store;
    logic     scan_start;
    logic     walk_init;
    logic     walk_forced;
    logic     walk_chk;
    logic     walk_sq;
    logic     walk_xy;
    logic     walk_acc;
    logic     walk_next;
    logic     walk_save;
    logic     mul_start;
    logic     mul_save;
    mul_sel_t mul_sel;
    logic     divm_start;
    logic     divs_start;
    logic     avg_raw;
    logic     avg_set;
    logic     slope_zero;
    logic     slope_set;
    logic     emit;
  } cmd_t;

  typedef struct packed {
    logic mode;
    logic due;
    logic scan_busy;
    logic chk_stop;
    logic chk_use;
    logic walk_last;
    logic forced;
    logic few;
    logic mul_busy;
    logic div_busy;
    logic avg_direct;
    logic den_pos;
    logic out_free;
  } sts_t;

endpackage

FILE: design/stms_intf.sv
// ----------------------------------------------------------------------------
// stms sample and report channels
// Valid/ready channels; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------
interface stms_sample_if;
  logic               valid;
  logic               ready;
  logic [31:0]        sample_time;
  logic signed [31:0] sample_value;

  modport source (output valid, sample_time, sample_value, input ready);
  modport sink   (input valid, sample_time, sample_value, output ready);
endinterface

interface stms_report_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] average;
  logic signed [31:0] slope;
  logic [31:0]        report_time;
  logic [6:0]         samples_used;

  modport source (output valid, average, slope, report_time, samples_used, input ready);
  modport sink   (input valid, average, slope, report_time, samples_used, output ready);
endinterface

FILE: design/stms_ram.sv
// ----------------------------------------------------------------------------
// stms_ram: generic single-port-write RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module stms_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: design/stms_mul.sv
// ----------------------------------------------------------------------------
// stms_mul: serial signed multiplier
// Shift-add over the magnitude of b, one bit per cycle, sign fixed last.
// ----------------------------------------------------------------------------
module stms_mul import stms_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic signed [WIDE_W-1:0]  a,
  input  logic signed [MUL_B_W-1:0] b,
  output logic                      busy,
  output logic signed [WIDE_W-1:0]  p
);

  logic [MUL_CNT_W-1:0] cnt_r;
  logic [WIDE_W-1:0]    acc_r;
  logic [WIDE_W-1:0]    am_r;
  logic [MUL_B_W-1:0]   bm_r;
  logic                 neg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      am_r  <= a[WIDE_W-1] ? -a : a;
      bm_r  <= b[MUL_B_W-1] ? -b : b;
      neg_r <= a[WIDE_W-1] ^ b[MUL_B_W-1];
      acc_r <= '0;
      cnt_r <= MUL_CNT_W'(MUL_B_W + 1);
    end else if (cnt_r != '0) begin
      if (cnt_r == MUL_CNT_W'(1)) begin
        acc_r <= neg_r ? -acc_r : acc_r;
      end else begin
        if (bm_r[0]) begin
          acc_r <= acc_r + am_r;
        end
        am_r <= am_r << 1;
        bm_r <= bm_r >> 1;
      end
      cnt_r <= cnt_r - MUL_CNT_W'(1);
    end
  end

  assign busy = (cnt_r != '0);
  assign p    = acc_r;

endmodule

FILE: design/stms_div.sv
// ----------------------------------------------------------------------------
// stms_div: restoring divider
// Unsigned, one quotient bit per cycle; first step flags a quotient that
// does not fit in Q_W bits.
// ----------------------------------------------------------------------------
module stms_div import stms_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [WIDE_W-1:0] dividend,
  input  logic [WIDE_W-1:0] divisor,
  output logic              busy,
  output logic [Q_W-1:0]    quot,
  output logic [WIDE_W-1:0] rem,
  output logic              ovf
);

  logic [DIV_CNT_W-1:0]    cnt_r;
  logic [WIDE_W-1:0]       rem_r;
  logic [WIDE_W+Q_W-1:0]   dsh_r;
  logic [Q_W-1:0]          q_r;
  logic                    ovf_r;
  logic                    ge;

  assign ge = ({{Q_W{1'b0}}, rem_r} >= dsh_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      rem_r <= dividend;
      dsh_r <= {divisor, {Q_W{1'b0}}};
      q_r   <= '0;
      ovf_r <= 1'b0;
      cnt_r <= DIV_CNT_W'(Q_W + 1);
    end else if (cnt_r != '0) begin
      if (cnt_r == DIV_CNT_W'(Q_W + 1)) begin
        ovf_r <= ge;
      end else begin
        if (ge) begin
          rem_r <= rem_r - dsh_r[WIDE_W-1:0];
        end
        q_r <= {q_r[Q_W-2:0], ge};
      end
      dsh_r <= dsh_r >> 1;
      cnt_r <= cnt_r - DIV_CNT_W'(1);
    end
  end

  assign busy = (cnt_r != '0);
  assign quot = q_r;
  assign rem  = rem_r;
  assign ovf  = ovf_r;

endmodule

FILE: design/stms_ctrl.sv
// ----------------------------------------------------------------------------
// stms_ctrl: sequencing controller
// Steps one sample through store, min/max scan, history walk, fit products,
// divisions and the result transfer.
// ----------------------------------------------------------------------------
module stms_ctrl import stms_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t   state_r, state_nxt;
  mul_sel_t msel_r, msel_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      msel_r  <= MSEL_N_SXY;
    end else begin
      state_r <= state_nxt;
      msel_r  <= msel_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt   = state_r;
    msel_nxt    = msel_r;
    cmd         = '0;
    cmd.mul_sel = msel_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_START;
        end
      end
      // mode 1 stores only when a report is due
      S_START: state_nxt = (!sts.mode || sts.due) ? S_STORE : S_IDLE;
      S_STORE: begin
        cmd.store      = 1'b1;
        cmd.scan_start = 1'b1;
        state_nxt      = S_SCAN;
      end
      S_SCAN: begin
        if (!sts.scan_busy) begin
          state_nxt = sts.due ? S_WINIT : S_IDLE;
        end
      end
      S_WINIT: begin
        cmd.walk_init = 1'b1;
        state_nxt     = S_WRD;
      end
      S_WRD: state_nxt = S_WCHK;
      S_WCHK: begin
        cmd.walk_chk = 1'b1;
        if (sts.chk_stop) begin
          state_nxt = S_WEND;
        end else if (sts.chk_use) begin
          state_nxt = S_WSQ;
        end else begin
          state_nxt = S_WNEXT;
        end
      end
      S_WSQ: begin
        cmd.walk_sq = 1'b1;
        state_nxt   = S_WXY;
      end
      S_WXY: begin
        cmd.walk_xy = 1'b1;
        state_nxt   = S_WACC;
      end
      S_WACC: begin
        cmd.walk_acc = 1'b1;
        state_nxt    = S_WNEXT;
      end
      S_WNEXT: begin
        if (sts.walk_last) begin
          state_nxt = S_WEND;
        end else begin
          cmd.walk_next = 1'b1;
          state_nxt     = S_WRD;
        end
      end
      S_WEND: begin
        if (!sts.forced) begin
          cmd.walk_save = 1'b1;
        end
        // too few points: refit over the two newest slots
        if (!sts.forced && sts.few) begin
          cmd.walk_init   = 1'b1;
          cmd.walk_forced = 1'b1;
          state_nxt       = S_WRD;
        end else begin
          msel_nxt  = MSEL_N_SXY;
          state_nxt = S_MULGO;
        end
      end
      S_MULGO: begin
        cmd.mul_start = 1'b1;
        state_nxt     = S_MULWAIT;
      end
      S_MULWAIT: begin
        if (!sts.mul_busy) begin
          cmd.mul_save = 1'b1;
          if (msel_r == MSEL_SX_SX) begin
            state_nxt = S_DIVM;
          end else begin
            msel_nxt  = mul_sel_t'(msel_r + 2'd1);
            state_nxt = S_MULGO;
          end
        end
      end
      S_DIVM: begin
        if (sts.avg_direct) begin
          cmd.avg_raw = 1'b1;
          state_nxt   = S_DIVS;
        end else begin
          cmd.divm_start = 1'b1;
          state_nxt      = S_DIVMW;
        end
      end
      S_DIVMW: begin
        if (!sts.div_busy) begin
          cmd.avg_set = 1'b1;
          state_nxt   = S_DIVS;
        end
      end
      S_DIVS: begin
        if (!sts.den_pos) begin
          cmd.slope_zero = 1'b1;
          state_nxt      = S_EMIT;
        end else begin
          cmd.divs_start = 1'b1;
          state_nxt      = S_DIVSW;
        end
      end
      S_DIVSW: begin
        if (!sts.div_busy) begin
          cmd.slope_set = 1'b1;
          state_nxt     = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

FILE: design/stms_dp.sv
// ----------------------------------------------------------------------------
// stms_dp: datapath
// Sample store with valid bits, min/max scan, walk accumulators, fit
// products, mean and slope division, report register.
// ----------------------------------------------------------------------------
module stms_dp import stms_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  logic [31:0]        in_time,
  input  logic signed [31:0] in_value,
  input  logic               out_ready,
  output logic               out_valid,
  output logic signed [31:0] out_average,
  output logic signed [31:0] out_slope,
  output logic [31:0]        out_time,
  output logic [USED_W-1:0]  out_used
);

  // sample and timing
  logic [31:0]        t_r;
  logic signed [31:0] v_r;
  logic               started_r;
  logic [31:0]        last_r;
  logic [31:0]        next_r;

  // store
  logic [SLOT_W-1:0]     newest_r;
  logic [SLOT_W-1:0]     newest_inc;
  logic [HIST_DEPTH-1:0] vld_r;
  logic                  rd_vld_r;
  logic [SLOT_W-1:0]     raddr;
  logic [RAM_W-1:0]      rdata;
  logic [31:0]           rd_time;
  logic signed [31:0]    rd_val;

  // min/max scan
  logic signed [31:0] min_r, max_r;
  logic               scan_on_r, scan_dv_r, scan_first_r;
  logic [SLOT_W-1:0]  scan_cnt_r;

  // walk
  logic [SLOT_W-1:0]         walk_slot_r;
  logic [SLOT_W-1:0]         walk_cnt_r;
  logic                      forced_r;
  logic [6:0]                dh_r, dl_r;
  logic [CNT_W-1:0]          n_r;
  logic signed [SUM_W-1:0]   sx_r, sy_r;
  logic signed [ACC_W-1:0]   sxx_r, sxy_r;
  logic signed [X_W-1:0]     x_r;
  logic signed [31:0]        y_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [X_W-1:0]     x_w;
  logic                      chk_stop, skip_hi, skip_lo, chk_use;

  // fit and report
  logic [CNT_W-1:0]          used_r;
  logic signed [SUM_W-1:0]   sum_r;
  logic signed [WIDE_W-1:0]  num_r, den_r;
  logic [31:0]               avg_r, slope_r;
  logic                      out_valid_r;
  logic [31:0]               oavg_r, oslope_r, otime_r;
  logic [USED_W-1:0]         oused_r;

  // shared units
  logic signed [WIDE_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic                      mul_busy;
  logic signed [WIDE_W-1:0]  mul_p;
  logic [WIDE_W-1:0]         div_dvd, div_dvs, div_rem;
  logic [Q_W-1:0]            div_q;
  logic                      div_busy, div_ovf;
  logic [SUM_W-1:0]          sum_mag;
  logic [WIDE_W-1:0]         num_mag;
  logic                      rnd;
  logic [Q_W:0]              q_rnd;
  logic [31:0]               q32;

  assign newest_inc = (newest_r == SLOT_W'(HIST_DEPTH - 1)) ? '0 : newest_r + SLOT_W'(1);
  assign raddr      = scan_on_r ? scan_cnt_r : walk_slot_r;

  stms_ram #(.WIDTH(RAM_W), .DEPTH(HIST_DEPTH)) u_ram (
    .clk   (clk),
    .we    (cmd.store),
    .waddr (newest_inc),
    .wdata ({t_r, v_r}),
    .raddr (raddr),
    .rdata (rdata)
  );

  // slots never written read as zero
  assign rd_time = rd_vld_r ? rdata[63:32] : 32'd0;
  assign rd_val  = rd_vld_r ? $signed(rdata[31:0]) : 32'sd0;
  assign x_w     = $signed({1'b0, rd_time}) - $signed({1'b0, t_r});

  assign chk_stop = !forced_r && (rd_time <= last_r);
  assign skip_hi  = !forced_r && (rd_val == max_r) && (dh_r != 7'd0);
  assign skip_lo  = !forced_r && !skip_hi && (rd_val == min_r) && (dl_r != 7'd0);
  assign chk_use  = !chk_stop && !skip_hi && !skip_lo;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r    <= 1'b0;
      last_r       <= '0;
      next_r       <= '0;
      newest_r     <= SLOT_W'(HIST_DEPTH - 1);
      vld_r        <= '0;
      min_r        <= '0;
      max_r        <= '0;
      scan_on_r    <= 1'b0;
      scan_dv_r    <= 1'b0;
      scan_first_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.accept && !started_r) begin
        started_r <= 1'b1;
        last_r    <= in_time + START_HOLDOFF;
        next_r    <= in_time + {16'd0, cfg.rpt_interval} + START_HOLDOFF;
      end
      if (cmd.store) begin
        newest_r          <= newest_inc;
        vld_r[newest_inc] <= 1'b1;
      end
      // scan issues one address a cycle, data arrives in the next cycle
      scan_dv_r <= scan_on_r;
      if (cmd.scan_start) begin
        scan_on_r    <= 1'b1;
        scan_first_r <= 1'b1;
      end else if (scan_on_r && scan_cnt_r == SLOT_W'(HIST_DEPTH - 1)) begin
        scan_on_r <= 1'b0;
      end
      if (scan_dv_r) begin
        scan_first_r <= 1'b0;
        if (scan_first_r || rd_val < min_r) begin
          min_r <= rd_val;
        end
        if (scan_first_r || rd_val > max_r) begin
          max_r <= rd_val;
        end
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
        last_r      <= t_r;
        next_r      <= t_r + {16'd0, cfg.rpt_interval};
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_vld_r <= vld_r[raddr];
    if (cmd.accept) begin
      t_r <= in_time;
      v_r <= in_value;
    end
    if (cmd.scan_start) begin
      scan_cnt_r <= '0;
    end else if (scan_on_r) begin
      scan_cnt_r <= scan_cnt_r + SLOT_W'(1);
    end

    if (cmd.walk_init) begin
      walk_slot_r <= newest_r;
      walk_cnt_r  <= '0;
      forced_r    <= cmd.walk_forced;
      dh_r        <= cfg.report_mode ? 7'd0 : cfg.discard_high;
      dl_r        <= cfg.report_mode ? 7'd0 : cfg.discard_low;
      n_r         <= '0;
      sx_r        <= '0;
      sy_r        <= '0;
      sxx_r       <= '0;
      sxy_r       <= '0;
    end
    if (cmd.walk_chk) begin
      if (skip_hi) begin
        dh_r <= dh_r - 7'd1;
      end else if (skip_lo) begin
        dl_r <= dl_r - 7'd1;
      end
      if (chk_use) begin
        x_r  <= x_w;
        y_r  <= rd_val;
        n_r  <= n_r + CNT_W'(1);
        sx_r <= sx_r + {{(SUM_W-X_W){x_w[X_W-1]}}, x_w};
        sy_r <= sy_r + {{(SUM_W-32){rd_val[31]}}, rd_val};
      end
    end
    if (cmd.walk_sq) begin
      prod_r <= x_r * x_r;
    end
    if (cmd.walk_xy) begin
      sxx_r  <= sxx_r + {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
      prod_r <= x_r * y_r;
    end
    if (cmd.walk_acc) begin
      sxy_r <= sxy_r + {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
    end
    if (cmd.walk_next) begin
      walk_slot_r <= (walk_slot_r == '0) ? SLOT_W'(HIST_DEPTH - 1) : walk_slot_r - SLOT_W'(1);
      walk_cnt_r  <= walk_cnt_r + SLOT_W'(1);
    end
    if (cmd.walk_save) begin
      used_r <= n_r;
      sum_r  <= sy_r;
    end

    if (cmd.mul_save) begin
      case (cmd.mul_sel)
        MSEL_N_SXY: num_r <= mul_p;
        MSEL_SX_SY: num_r <= num_r - mul_p;
        MSEL_N_SXX: den_r <= mul_p;
        MSEL_SX_SX: den_r <= den_r - mul_p;
        default:    den_r <= den_r;
      endcase
    end

    if (cmd.avg_raw) begin
      avg_r <= v_r;
    end
    if (cmd.avg_set) begin
      avg_r <= sum_r[SUM_W-1] ? -q32 : q32;
    end
    if (cmd.slope_zero) begin
      slope_r <= '0;
    end
    if (cmd.slope_set) begin
      if (!num_r[WIDE_W-1]) begin
        if (div_ovf || q_rnd > (Q_W+1)'(32'h7FFF_FFFF)) begin
          slope_r <= 32'h7FFF_FFFF;
        end else begin
          slope_r <= q_rnd[31:0];
        end
      end else begin
        if (div_ovf || q_rnd > (Q_W+1)'(32'h8000_0000)) begin
          slope_r <= 32'h8000_0000;
        end else begin
          slope_r <= -q_rnd[31:0];
        end
      end
    end

    if (cmd.emit) begin
      oavg_r   <= avg_r;
      oslope_r <= slope_r;
      otime_r  <= t_r;
      oused_r  <= (used_r > CNT_W'(127)) ? USED_W'(127) : USED_W'(used_r);
    end
  end

  // fit products: num = n*Sxy - Sx*Sy, den = n*Sxx - Sx*Sx
  always_comb begin
    case (cmd.mul_sel)
      MSEL_N_SXY: begin
        mul_a = {{(WIDE_W-ACC_W){sxy_r[ACC_W-1]}}, sxy_r};
        mul_b = {{(MUL_B_W-CNT_W){1'b0}}, n_r};
      end
      MSEL_SX_SY: begin
        mul_a = {{(WIDE_W-SUM_W){sx_r[SUM_W-1]}}, sx_r};
        mul_b = sy_r;
      end
      MSEL_N_SXX: begin
        mul_a = {{(WIDE_W-ACC_W){sxx_r[ACC_W-1]}}, sxx_r};
        mul_b = {{(MUL_B_W-CNT_W){1'b0}}, n_r};
      end
      default: begin
        mul_a = {{(WIDE_W-SUM_W){sx_r[SUM_W-1]}}, sx_r};
        mul_b = sx_r;
      end
    endcase
  end

  stms_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .busy  (mul_busy),
    .p     (mul_p)
  );

  // mean is (2|sum| + n) / 2n, rounding half away from zero
  assign sum_mag = sum_r[SUM_W-1] ? -sum_r : sum_r;
  assign num_mag = num_r[WIDE_W-1] ? -num_r : num_r;
  assign div_dvd = cmd.divs_start ? num_mag
                 : WIDE_W'({sum_mag, 1'b0}) + WIDE_W'(used_r);
  assign div_dvs = cmd.divs_start ? den_r : WIDE_W'({used_r, 1'b0});

  stms_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.divm_start | cmd.divs_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .busy     (div_busy),
    .quot     (div_q),
    .rem      (div_rem),
    .ovf      (div_ovf)
  );

  assign q32   = div_q[31:0];
  assign rnd   = ({div_rem, 1'b0} >= {1'b0, den_r});
  assign q_rnd = {1'b0, div_q} + (Q_W+1)'(rnd);

  assign sts.mode       = cfg.report_mode;
  assign sts.due        = (next_r <= t_r);
  assign sts.scan_busy  = scan_on_r | scan_dv_r;
  assign sts.chk_stop   = chk_stop;
  assign sts.chk_use    = chk_use;
  assign sts.walk_last  = (walk_cnt_r == (forced_r ? SLOT_W'(1) : SLOT_W'(HIST_DEPTH - 1)));
  assign sts.forced     = forced_r;
  assign sts.few        = (n_r <= CNT_W'(1));
  assign sts.mul_busy   = mul_busy;
  assign sts.div_busy   = div_busy;
  assign sts.avg_direct = cfg.report_mode || (used_r == '0);
  assign sts.den_pos    = !den_r[WIDE_W-1] && (den_r != '0);
  assign sts.out_free   = !out_valid_r || out_ready;

  assign out_valid   = out_valid_r;
  assign out_average = oavg_r;
  assign out_slope   = oslope_r;
  assign out_time    = otime_r;
  assign out_used    = oused_r;

endmodule

FILE: design/sensor_trimmed_mean_slope_top.sv
// ----------------------------------------------------------------------------
// sensor_trimmed_mean_slope_top: trimmed mean and least-squares slope
// Timestamped Q16.16 samples go into a 64-entry history; when a report is
// due the block emits the trimmed mean and the fitted slope per second.
// ----------------------------------------------------------------------------
// Samples are taken one at a time. A sample that brings no report goes
// through one write and a 64-entry min/max scan through the single read
// port of the history RAM; in report mode 1 a sample that is not due is
// dropped. A report adds the history walk over up to 64 slots, four serial
// products and up to two divisions. A finished report waits in the output
// register and the next sample is taken meanwhile. The history reads as
// zero after reset through per-slot valid bits, so no clearing pass is
// needed.
module sensor_trimmed_mean_slope_top import stms_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  stms_sample_if.sink           in_chan,
  stms_report_if.source         out_chan,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  cfg_t     cfg_r;
  cmd_t     cmd;
  sts_t     sts;
  reg_idx_t reg_idx;

  assign reg_idx = reg_idx_t'(paddr[3:2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rpt_interval <= 16'd10;
      cfg_r.discard_high <= 7'd1;
      cfg_r.discard_low  <= 7'd1;
      cfg_r.report_mode  <= 1'b0;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_RPT_INTERVAL: cfg_r.rpt_interval <= pwdata[15:0];
        REG_DISCARD_HIGH: cfg_r.discard_high <= pwdata[6:0];
        REG_DISCARD_LOW:  cfg_r.discard_low  <= pwdata[6:0];
        REG_REPORT_MODE:  cfg_r.report_mode  <= pwdata[0];
        default:          cfg_r              <= cfg_r;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_RPT_INTERVAL: prdata = {16'd0, cfg_r.rpt_interval};
      REG_DISCARD_HIGH: prdata = {25'd0, cfg_r.discard_high};
      REG_DISCARD_LOW:  prdata = {25'd0, cfg_r.discard_low};
      REG_REPORT_MODE:  prdata = {31'd0, cfg_r.report_mode};
      default:          prdata = '0;
    endcase
  end

  stms_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  stms_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .cmd         (cmd),
    .sts         (sts),
    .in_time     (in_chan.sample_time),
    .in_value    (in_chan.sample_value),
    .out_ready   (out_chan.ready),
    .out_valid   (out_chan.valid),
    .out_average (out_chan.average),
    .out_slope   (out_chan.slope),
    .out_time    (out_chan.report_time),
    .out_used    (out_chan.samples_used)
  );

endmodule
